// ===== rtl/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line point rasterizer package
// Shared widths, register indexes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int MAX_POINTS = 64;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W = 12;           // endpoint and point coordinate width
    localparam int COLOR_W = 24;
    localparam int STEP_W  = 4;
    localparam int CFG_W   = 12;           // widest configuration register
    localparam int IDX_W   = 2;

    localparam int MAJ_W   = COORD_W + 2;  // major coordinate, room for one overshoot
    localparam int LEN_W   = COORD_W + 1;  // span plus one, up to 4096
    localparam int NUM_W   = 26;           // weighted-sum numerator, signed
    localparam int DELTA_W = STEP_W + 1 + LEN_W;
    localparam int QUO_W   = COORD_W;      // magnitude of the interpolated minor
    localparam int DIV_CNT_W = $clog2(QUO_W);

    typedef enum logic [IDX_W-1:0] {
        REG_PIXEL_STEP   = 2'd0,
        REG_WIDTH_LIMIT  = 2'd1,
        REG_HEIGHT_LIMIT = 2'd2
    } reg_index_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ORDER = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_EMIT  = 6'b100000
    } ctrl_state_t;

    typedef struct packed {
        logic capture;   // take the input beat
        logic order;     // pick major axis and order endpoints
        logic setup;     // first numerator, increment, span
        logic load;      // start a division for the current point
        logic div_step;  // one quotient bit
        logic emit;      // write the output register and advance
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;  // the current division step is the final one
        logic out_free;  // output register can take a point this cycle
        logic last;      // the pending point ends the segment
    } dp_status_t;

endpackage

// ===== rtl/lpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Line point rasterizer controller
// Sequences segment setup, one division per point and the hand-off of each
// point into the output register.
// ----------------------------------------------------------------------------
module lpr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output lpr_pkg::dp_cmd_t   cmd,
    input  lpr_pkg::dp_status_t status
);
    import lpr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ORDER;
                end
            end
            ST_ORDER:
            begin
                cmd.order  = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.last ? ST_IDLE : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lpr_dp.sv =====
// ----------------------------------------------------------------------------
// Line point rasterizer datapath
// Configuration registers, endpoint ordering, incremental numerator,
// restoring divider, clamping and the output register.
// ----------------------------------------------------------------------------
module lpr_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lpr_pkg::IDX_W-1:0]     cfg_index,
    input  logic [lpr_pkg::CFG_W-1:0]     cfg_data,
    input  logic signed [lpr_pkg::COORD_W-1:0] start_x,
    input  logic signed [lpr_pkg::COORD_W-1:0] start_y,
    input  logic signed [lpr_pkg::COORD_W-1:0] end_x,
    input  logic signed [lpr_pkg::COORD_W-1:0] end_y,
    input  logic [lpr_pkg::COLOR_W-1:0]   color_rgb,
    input  lpr_pkg::dp_cmd_t              cmd,
    output lpr_pkg::dp_status_t           status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lpr_pkg::COORD_W-1:0]   point_x,
    output logic [lpr_pkg::COORD_W-1:0]   point_y,
    output logic [lpr_pkg::COLOR_W-1:0]   point_color,
    output logic                          last_point,
    output logic                          cut_short
);
    import lpr_pkg::*;

    // Clamp a signed coordinate to the range zero through the limit.
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [MAJ_W-1:0] v,
        input logic [COORD_W-1:0]      lim
    );
        logic signed [MAJ_W-1:0] lim_ext;
        lim_ext = $signed({{(MAJ_W-COORD_W){1'b0}}, lim});
        if (v < 0)
            clamp_coord = '0;
        else if (v > lim_ext)
            clamp_coord = lim;
        else
            clamp_coord = v[COORD_W-1:0];
    endfunction

    // Configuration registers
    logic [STEP_W-1:0]  pixel_step_reg;
    logic [COORD_W-1:0] width_limit_reg;
    logic [COORD_W-1:0] height_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_step_reg   <= STEP_W'(3);
            width_limit_reg  <= COORD_W'(1999);
            height_limit_reg <= COORD_W'(999);
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_PIXEL_STEP:   pixel_step_reg   <= cfg_data[STEP_W-1:0];
                REG_WIDTH_LIMIT:  width_limit_reg  <= cfg_data[COORD_W-1:0];
                REG_HEIGHT_LIMIT: height_limit_reg <= cfg_data[COORD_W-1:0];
                default:          ;
            endcase
        end
    end

    logic [STEP_W-1:0] step_eff;
    assign step_eff = (pixel_step_reg == '0) ? STEP_W'(1) : pixel_step_reg;

    // Captured segment
    logic signed [COORD_W-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic [COLOR_W-1:0]        color_reg;

    // Ordered segment
    logic                      xmajor_reg;
    logic signed [COORD_W-1:0] lo_maj_reg, hi_maj_reg, lo_min_reg, hi_min_reg;

    // Per-point walk
    logic signed [MAJ_W-1:0]   m_reg, hi_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [CNT_W-1:0]          cnt_reg;

    // Divider
    logic [LEN_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Ordering logic
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W:0]        adx, ady;
    logic                    xmajor_next;

    always_comb
    begin
        dx  = {xa_reg[COORD_W-1], xa_reg} - {xb_reg[COORD_W-1], xb_reg};
        dy  = {ya_reg[COORD_W-1], ya_reg} - {yb_reg[COORD_W-1], yb_reg};
        adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
        ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
        xmajor_next = (adx >= ady);
    end

    // Setup arithmetic: first numerator is lo_min * span + hi_min.
    logic [COORD_W:0]          span;
    logic signed [NUM_W-1:0]   num_first;
    logic signed [COORD_W:0]   min_diff;
    logic signed [DELTA_W-1:0] delta_first;

    always_comb
    begin
        span = {hi_maj_reg[COORD_W-1], hi_maj_reg} - {lo_maj_reg[COORD_W-1], lo_maj_reg};
        num_first = NUM_W'(lo_min_reg) * $signed(NUM_W'({1'b0, span}))
                  + NUM_W'(hi_min_reg);
        min_diff = {hi_min_reg[COORD_W-1], hi_min_reg}
                 - {lo_min_reg[COORD_W-1], lo_min_reg};
        delta_first = DELTA_W'($signed({1'b0, step_eff})) * DELTA_W'(min_diff);
    end

    // Divider step and start values
    logic [NUM_W-1:0]   num_mag;
    logic [LEN_W:0]     trial;
    logic               take;

    always_comb
    begin
        num_mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        trial   = {rem_reg, quo_reg[QUO_W-1]};
        take    = (trial >= {1'b0, len_reg});
    end

    // Point values
    logic signed [MAJ_W-1:0] minor_val, px, py, m_next;
    logic                    more;
    logic                    cnt_final;

    always_comb
    begin
        minor_val = neg_reg ? -$signed({{(MAJ_W-QUO_W){1'b0}}, quo_reg})
                            :  $signed({{(MAJ_W-QUO_W){1'b0}}, quo_reg});
        px        = xmajor_reg ? m_reg : minor_val;
        py        = xmajor_reg ? minor_val : m_reg;
        m_next    = m_reg + $signed({{(MAJ_W-STEP_W){1'b0}}, step_eff});
        more      = (m_next <= hi_reg);
        cnt_final = (cnt_reg == CNT_W'(MAX_POINTS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            xa_reg    <= start_x;
            ya_reg    <= start_y;
            xb_reg    <= end_x;
            yb_reg    <= end_y;
            color_reg <= color_rgb;
        end
        if (cmd.order)
        begin
            xmajor_reg <= xmajor_next;
            if (xmajor_next)
            begin
                if (xa_reg > xb_reg)
                begin
                    lo_maj_reg <= xb_reg; hi_maj_reg <= xa_reg;
                    lo_min_reg <= yb_reg; hi_min_reg <= ya_reg;
                end
                else
                begin
                    lo_maj_reg <= xa_reg; hi_maj_reg <= xb_reg;
                    lo_min_reg <= ya_reg; hi_min_reg <= yb_reg;
                end
            end
            else
            begin
                if (ya_reg > yb_reg)
                begin
                    lo_maj_reg <= yb_reg; hi_maj_reg <= ya_reg;
                    lo_min_reg <= xb_reg; hi_min_reg <= xa_reg;
                end
                else
                begin
                    lo_maj_reg <= ya_reg; hi_maj_reg <= yb_reg;
                    lo_min_reg <= xa_reg; hi_min_reg <= xb_reg;
                end
            end
        end
        if (cmd.setup)
        begin
            num_reg   <= num_first;
            delta_reg <= delta_first;
            len_reg   <= LEN_W'(span) + LEN_W'(1);
            m_reg     <= MAJ_W'(lo_maj_reg);
            hi_reg    <= MAJ_W'(hi_maj_reg);
        end
        else if (cmd.emit)
        begin
            num_reg <= num_reg + NUM_W'(delta_reg);
            m_reg   <= m_next;
        end
        // The quotient magnitude never exceeds 2048, so the upper numerator
        // bits start out already below the divisor.
        if (cmd.load)
        begin
            neg_reg     <= num_reg[NUM_W-1];
            rem_reg     <= LEN_W'(num_mag[2*QUO_W-1:QUO_W]);
            quo_reg     <= num_mag[QUO_W-1:0];
            div_cnt_reg <= DIV_CNT_W'(QUO_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= take ? LEN_W'(trial - {1'b0, len_reg}) : trial[LEN_W-1:0];
            quo_reg     <= {quo_reg[QUO_W-2:0], take};
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.setup)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.emit)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Output register
    logic                out_valid_reg;
    logic [COORD_W-1:0]  point_x_reg, point_y_reg;
    logic [COLOR_W-1:0]  point_color_reg;
    logic                last_point_reg, cut_short_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            point_x_reg     <= clamp_coord(px, width_limit_reg);
            point_y_reg     <= clamp_coord(py, height_limit_reg);
            point_color_reg <= color_reg;
            last_point_reg  <= status.last;
            cut_short_reg   <= more && cnt_final;
        end
    end

    always_comb
    begin
        status.div_last = (div_cnt_reg == '0);
        status.out_free = !out_valid_reg || !out_stall;
        status.last     = !more || cnt_final;
    end

    assign out_valid   = out_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign point_color = point_color_reg;
    assign last_point  = last_point_reg;
    assign cut_short   = cut_short_reg;

endmodule

// ===== rtl/line_point_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// Line point rasterizer
// Turns one line segment into up to 64 clamped, colored points.
// ----------------------------------------------------------------------------
// One segment is taken per beat and the block takes no new segment until the
// last point of the current one has been written into the output register.
// Setup runs through capture, axis choice and ordering, and the first
// numerator; then each point loads the divider, runs the bit-serial division
// of the weighted sum by the span plus one, and writes the output register,
// which waits while the output side stalls. The next segment may be accepted
// while the final point still waits in the output register.
module line_point_rasterizer_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lpr_pkg::IDX_W-1:0]          cfg_index,
    input  logic [lpr_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [lpr_pkg::COORD_W-1:0] start_x,
    input  logic signed [lpr_pkg::COORD_W-1:0] start_y,
    input  logic signed [lpr_pkg::COORD_W-1:0] end_x,
    input  logic signed [lpr_pkg::COORD_W-1:0] end_y,
    input  logic [lpr_pkg::COLOR_W-1:0]        color_rgb,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lpr_pkg::COORD_W-1:0]        point_x,
    output logic [lpr_pkg::COORD_W-1:0]        point_y,
    output logic [lpr_pkg::COLOR_W-1:0]        point_color,
    output logic                               last_point,
    output logic                               cut_short
);
    import lpr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    lpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    lpr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .color_rgb   (color_rgb),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_color (point_color),
        .last_point  (last_point),
        .cut_short   (cut_short)
    );

endmodule
